>>> rtl/assert_macros.svh
// Assertion macros used by the port checker of the word search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define GWS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gws: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define GWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gws: next-cycle check failed");

`endif

>>> rtl/gws_pkg.sv
// Package of the word search block: sizes, codes, direction steps and shared types.
package gws_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int MAX_WORD = 16;

	localparam int ROW_W    = 4;
	localparam int COL_W    = 4;
	localparam int CNT_W    = 5;
	localparam int LETTER_W = 8;
	localparam int IDX_W    = 4;
	localparam int LEN_W    = 5;
	localparam int NDIR     = 8;
	localparam int DIR_W    = 3;
	localparam int GA_W     = ROW_W + COL_W;
	localparam int POS_W    = ROW_W + 2;
	localparam int NRAM     = NDIR / 2;

	typedef logic [1:0]          mode_t;
	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [GA_W-1:0]     gaddr_t;

	localparam mode_t MODE_CELL   = 2'd0;
	localparam mode_t MODE_LETTER = 2'd1;
	localparam mode_t MODE_QUERY  = 2'd2;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// One compare beat handed from the sequencer to the match stage
	typedef struct packed {
		logic            issue;
		logic            last;
		logic [NDIR-1:0] inb;
	} gws_issue_t;

	// Row step per direction: up, down, right, left, ur, ul, dr, dl
	function automatic logic signed [1:0] step_r(input logic [DIR_W-1:0] d);
		logic signed [1:0] s;
		case (d)
			3'd0, 3'd4, 3'd5: s = -2'sd1;
			3'd1, 3'd6, 3'd7: s = 2'sd1;
			default:          s = 2'sd0;
		endcase
		return s;
	endfunction

	// Column step per direction
	function automatic logic signed [1:0] step_c(input logic [DIR_W-1:0] d);
		logic signed [1:0] s;
		case (d)
			3'd2, 3'd4, 3'd6: s = 2'sd1;
			3'd3, 3'd5, 3'd7: s = -2'sd1;
			default:          s = 2'sd0;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/gws_ram.sv
// Generic RAM: one write port, two registered read ports.
module gws_ram #(
	parameter int AW = 8,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] wa,
	input  logic [DW-1:0] wd,
	input  logic [AW-1:0] ra0,
	input  logic [AW-1:0] ra1,
	output logic [DW-1:0] rd0,
	output logic [DW-1:0] rd1
);

	logic [DW-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd0 <= mem_q[ra0];
		rd1 <= mem_q[ra1];
	end

endmodule

>>> rtl/gws_walk.sv
// Path walker: per-direction cell positions, grid addresses and in-bounds flags.
module gws_walk import gws_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [ROW_W-1:0] r0,
	input  logic [COL_W-1:0] c0,
	input  logic [CNT_W-1:0] nrows,
	input  logic [CNT_W-1:0] ncols,
	output gaddr_t           addr [NDIR],
	output logic [NDIR-1:0]  inb
);

	logic signed [POS_W-1:0] pos_r_q [NDIR];
	logic signed [POS_W-1:0] pos_c_q [NDIR];

	// Start all paths at the query cell, then move one cell per beat
	always_ff @(posedge clk) begin
		for (int d = 0; d < NDIR; d++) begin
			if (load) begin
				pos_r_q[d] <= $signed(POS_W'(r0));
				pos_c_q[d] <= $signed(POS_W'(c0));
			end else if (step) begin
				pos_r_q[d] <= pos_r_q[d] + POS_W'(step_r(DIR_W'(d)));
				pos_c_q[d] <= pos_c_q[d] + POS_W'(step_c(DIR_W'(d)));
			end
		end
	end

	// Bounds against the grid in use; address is row-major
	always_comb begin
		for (int d = 0; d < NDIR; d++) begin
			inb[d] = !pos_r_q[d][POS_W-1] && !pos_c_q[d][POS_W-1]
				&& (pos_r_q[d] < $signed(POS_W'(nrows)))
				&& (pos_c_q[d] < $signed(POS_W'(ncols)));
			addr[d] = {pos_r_q[d][ROW_W-1:0], pos_c_q[d][COL_W-1:0]};
		end
	end

endmodule

>>> rtl/gws_match.sv
// Match stage: word letter memory, per-direction live mask and first-hit result.
module gws_match import gws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_we,
	input  logic [IDX_W-1:0] word_wa,
	input  letter_t          word_wd,
	input  logic [IDX_W-1:0] word_ra,
	input  gws_issue_t       issue,
	input  logic             fail,
	input  letter_t          grid_rd [NDIR],
	output logic             done,
	output logic             found,
	output logic [DIR_W-1:0] direction
);

	letter_t         word_mem_q [MAX_WORD];
	letter_t         word_rd_s1;
	gws_issue_t      issue_s1;
	logic [NDIR-1:0] alive_q;
	logic [NDIR-1:0] hit;
	logic [DIR_W-1:0] first;

	// Word letters; read lines up with the grid read data
	always_ff @(posedge clk) begin
		if (word_we) begin
			word_mem_q[word_wa] <= word_wd;
		end
		word_rd_s1 <= word_mem_q[word_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
		end else begin
			issue_s1 <= issue;
		end
	end

	// Directions still matching after this beat
	always_comb begin
		for (int d = 0; d < NDIR; d++) begin
			hit[d] = alive_q[d] && issue_s1.inb[d] && (grid_rd[d] == word_rd_s1);
		end
		first = '0;
		for (int d = NDIR - 1; d >= 0; d--) begin
			if (hit[d]) begin
				first = DIR_W'(d);
			end
		end
	end

	// Live mask rearms after the last letter of each query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
		end else if (issue_s1.issue) begin
			alive_q <= issue_s1.last ? '1 : hit;
		end
	end

	// Result strobe: end of a walk, or a query rejected up front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done      <= 1'b0;
			found     <= 1'b0;
			direction <= '0;
		end else begin
			done <= (issue_s1.issue && issue_s1.last) || fail;
			if (fail) begin
				found     <= 1'b0;
				direction <= '0;
			end else begin
				found     <= |hit;
				direction <= first;
			end
		end
	end

endmodule

>>> rtl/grid_word_search_8dir_top.sv
// Top level of the eight-direction word search block.
//
// Command channel: an item is taken at a rising edge with start high and busy low.
// mode selects a grid cell load, a word letter load, or a query of a start cell.
// Loads finish in the cycle they are taken and give no result.
// A query gives one result: done is high for exactly one cycle with found and
// direction (first matching of up, down, right, left, up-right, up-left,
// down-right, down-left; 0 when not found). The receiver cannot stall it.
// A query that can be rejected at once (start outside the grid in use, word
// shorter than two letters) strobes done in the cycle after it is taken.
// Otherwise busy stays high through the walk and falls in the same cycle as
// the done strobe: one word letter is compared per cycle in all eight
// directions, with the grid read through four two-port RAM copies.
// Configuration: cfg_we with cfg_index 0 (rows in use) or 1 (columns in use).
// Reset: rows and columns in use return to 16, word length to zero; grid and
// word contents stay undefined until loaded.
module grid_word_search_8dir_top import gws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       mode,
	input  logic [ROW_W-1:0] row,
	input  logic [COL_W-1:0] col,
	input  logic [7:0]       letter,
	input  logic [IDX_W-1:0] letter_index,
	input  logic             last_letter,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             done,
	output logic             found,
	output logic [DIR_W-1:0] direction
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0] nrows_q, ncols_q;
	logic [CNT_W-1:0] nrows_sat, ncols_sat;
	logic [LEN_W-1:0] word_len_q;
	logic [IDX_W-1:0] k_q, last_k_q;
	logic             accept, query, start_ok, fail;
	logic             cell_we, word_we;
	gaddr_t           addr [NDIR];
	logic [NDIR-1:0]  inb;
	letter_t          grid_rd [NDIR];
	gws_issue_t       issue;
	logic             step;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign query  = accept && (mode == MODE_QUERY);

	// Grid in use, saturated to the storage size
	assign nrows_sat = (rows_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_q;
	assign ncols_sat = (cols_q > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_q;

	assign start_ok = (word_len_q >= LEN_W'(2))
		&& (CNT_W'(row) < nrows_sat) && (CNT_W'(col) < ncols_sat);
	assign fail = query && !start_ok;

	// Loads outside storage are dropped
	assign cell_we = accept && (mode == MODE_CELL)
		&& (CNT_W'(row) < CNT_W'(MAX_ROWS)) && (CNT_W'(col) < CNT_W'(MAX_COLS));
	assign word_we = accept && (mode == MODE_LETTER)
		&& (CNT_W'(letter_index) < CNT_W'(MAX_WORD));

	assign step        = (state_q == ST_RUN);
	assign issue.issue = step;
	assign issue.last  = (k_q == last_k_q);
	assign issue.inb   = inb;

	// Configuration registers and word length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= CNT_W'(16);
			cols_q     <= CNT_W'(16);
			word_len_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS: rows_q <= cfg_wdata;
					CFG_COLS: cols_q <= cfg_wdata;
				endcase
			end
			if (word_we && last_letter) begin
				word_len_q <= LEN_W'(letter_index) + LEN_W'(1);
			end
		end
	end

	// Query sequencer: one word letter per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			last_k_q <= '0;
			nrows_q  <= '0;
			ncols_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query && start_ok) begin
						state_q  <= ST_RUN;
						k_q      <= '0;
						last_k_q <= IDX_W'(word_len_q - LEN_W'(1));
						nrows_q  <= nrows_sat;
						ncols_q  <= ncols_sat;
					end
				end
				ST_RUN: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == last_k_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	gws_walk u_walk (
		.clk   (clk),
		.load  (query),
		.step  (step),
		.r0    (row),
		.c0    (col),
		.nrows (nrows_q),
		.ncols (ncols_q),
		.addr  (addr),
		.inb   (inb)
	);

	// Grid copies: two directions read per copy; loads never overlap a walk
	for (genvar g = 0; g < NRAM; g++) begin : g_grid
		gws_ram #(
			.AW (GA_W),
			.DW (LETTER_W)
		) u_ram (
			.clk (clk),
			.we  (cell_we),
			.wa  ({row, col}),
			.wd  (letter),
			.ra0 (addr[2*g]),
			.ra1 (addr[2*g+1]),
			.rd0 (grid_rd[2*g]),
			.rd1 (grid_rd[2*g+1])
		);
	end

	gws_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_we   (word_we),
		.word_wa   (letter_index),
		.word_wd   (letter),
		.word_ra   (k_q),
		.issue     (issue),
		.fail      (fail),
		.grid_rd   (grid_rd),
		.done      (done),
		.found     (found),
		.direction (direction)
	);

endmodule

>>> rtl/gws_checker.sv
// Port-level checker for the word search block, bound to the top level.
`include "assert_macros.svh"

module gws_port_checker import gws_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [1:0]       mode,
	input logic             done,
	input logic             found,
	input logic [DIR_W-1:0] direction
);

	// A miss always reports direction zero
	`GWS_ASSERT_SAME(a_miss_dir_zero, done && !found, direction == '0)

	// Loads and unused codes never hold the block busy
	`GWS_ASSERT_NEXT(a_load_no_busy, start && !busy && (mode != MODE_QUERY), !busy)

	// The end of a walk comes with its result beat
	`GWS_ASSERT_SAME(a_walk_end_result, $fell(busy), done)

endmodule

bind grid_word_search_8dir_top gws_port_checker u_gws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.mode      (mode),
	.done      (done),
	.found     (found),
	.direction (direction)
);
